[hw/rtl/eaam_pkg.sv]
package eaam_pkg;

  localparam int CORDIC_STEPS           = 32;
  localparam int GUARD_BITS             = 2;
  localparam int ANGLE_BITS_DEF         = 16;
  localparam int TRIG_FRACTION_BITS_DEF = 16;
  localparam int FIFO_DEPTH             = 4;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam logic [1:0]  LAST_ROW = 2'd2;

  // Arc tangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] a;
    case (i)
      0:       a = 32'h20000000;
      1:       a = 32'h12E4051E;
      2:       a = 32'h09FB385B;
      3:       a = 32'h051111D4;
      4:       a = 32'h028B0D43;
      5:       a = 32'h0145D7E1;
      6:       a = 32'h00A2F61E;
      7:       a = 32'h00517C55;
      8:       a = 32'h0028BE53;
      9:       a = 32'h00145F2F;
      10:      a = 32'h000A2F98;
      11:      a = 32'h000517CC;
      12:      a = 32'h00028BE6;
      13:      a = 32'h000145F3;
      14:      a = 32'h0000A2FA;
      15:      a = 32'h0000517D;
      16:      a = 32'h000028BE;
      17:      a = 32'h0000145F;
      18:      a = 32'h00000A30;
      19:      a = 32'h00000518;
      20:      a = 32'h0000028C;
      21:      a = 32'h00000146;
      22:      a = 32'h000000A3;
      23:      a = 32'h00000051;
      24:      a = 32'h00000029;
      25:      a = 32'h00000014;
      26:      a = 32'h0000000A;
      27:      a = 32'h00000005;
      28:      a = 32'h00000003;
      29:      a = 32'h00000001;
      30:      a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // CORDIC start value: the gain rounded to the working fraction width.
  function automatic logic [63:0] cordic_gain(input int work);
    logic [63:0] g;
    int          drop;
    drop = 32 - work;
    g    = 64'(GAIN_Q32);
    if (drop > 0) begin
      g = (g + (64'd1 << (drop - 1))) >> drop;
    end
    return g;
  endfunction

  // Keeps the top angle bits of a 16-bit binary angle.
  function automatic logic [15:0] angle_mask(input int ab);
    logic [15:0] m;
    if (ab >= 16) begin
      m = 16'hFFFF;
    end else begin
      m = ~16'((17'd1 << (16 - ab)) - 17'd1);
    end
    return m;
  endfunction

endpackage

[hw/rtl/eaam_cordic.sv]
module eaam_cordic #(
  parameter int ANGLE_BITS         = eaam_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRACTION_BITS = eaam_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [15:0]                     angle,
  output logic signed [TRIG_FRACTION_BITS+1:0] sin_o,
  output logic signed [TRIG_FRACTION_BITS+1:0] cos_o
);

  localparam int TF = TRIG_FRACTION_BITS;
  localparam int W  = TF + eaam_pkg::GUARD_BITS;
  localparam int XW = W + 3;
  localparam int ZW = 34;
  localparam int T  = TF + 2;
  localparam int N  = eaam_pkg::CORDIC_STEPS;

  localparam logic [15:0]            AMASK = eaam_pkg::angle_mask(ANGLE_BITS);
  localparam logic signed [XW-1:0]   GAIN  = XW'(eaam_pkg::cordic_gain(W));
  localparam logic signed [XW-1:0]   ONE   = XW'(64'd1 << TF);
  localparam logic signed [XW-1:0]   NONE  = -ONE;
  localparam logic signed [XW-1:0]   RND   = XW'(64'd1 << (eaam_pkg::GUARD_BITS - 1));

  logic signed [XW-1:0] x_r [0:N-1];
  logic signed [XW-1:0] y_r [0:N-1];
  logic signed [ZW-1:0] z_r [0:N-1];
  logic [1:0]           q_r [0:N-1];

  logic [15:0]          masked;
  logic signed [ZW-1:0] z0;

  assign masked = angle & AMASK;
  assign z0     = ZW'({masked[13:0], 16'b0});

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(eaam_pkg::atan_entry(k));
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic [1:0]           qi;
    if (k == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = z0;
      assign qi = masked[15:14];
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign qi = q_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - AT;
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + AT;
        end
        q_r[k] <= qi;
      end
    end
  end

  logic signed [XW-1:0] xr, yr, xc, yc;
  logic signed [T-1:0]  c, s;

  assign xr = (x_r[N-1] + RND) >>> eaam_pkg::GUARD_BITS;
  assign yr = (y_r[N-1] + RND) >>> eaam_pkg::GUARD_BITS;
  assign xc = (xr > ONE) ? ONE : ((xr < NONE) ? NONE : xr);
  assign yc = (yr > ONE) ? ONE : ((yr < NONE) ? NONE : yr);
  assign c  = T'(xc);
  assign s  = T'(yc);

  // Fold the first-quadrant result into the quadrant of the phase.
  always_comb begin
    case (q_r[N-1])
      2'd1: begin
        cos_o = -s;
        sin_o = c;
      end
      2'd2: begin
        cos_o = -c;
        sin_o = -s;
      end
      2'd3: begin
        cos_o = s;
        sin_o = -c;
      end
      default: begin
        cos_o = c;
        sin_o = s;
      end
    endcase
  end

endmodule

[hw/rtl/eaam_front.sv]
module eaam_front #(
  parameter int ANGLE_BITS         = eaam_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRACTION_BITS = eaam_pkg::TRIG_FRACTION_BITS_DEF,
  parameter int DW                 = 6 * (TRIG_FRACTION_BITS + 2) + 97
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [143:0]  in_data,
  input  logic          in_op,
  output logic          push,
  output logic [DW-1:0] push_data,
  input  logic          full
);

  localparam int T = TRIG_FRACTION_BITS + 2;
  localparam int N = eaam_pkg::CORDIC_STEPS;

  logic [N-1:0] v_r;
  logic [96:0]  p_r [0:N-1];
  logic         en;

  logic signed [T-1:0] sp, cp, sy, cy, sr, cr;

  assign en       = !(v_r[N-1] && full);
  assign in_ready = en;
  assign push     = v_r[N-1] && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  // Mode bit and origin ride alongside the CORDIC stages.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= {in_data[143:48], in_op};
      for (int k = 1; k < N; k++) begin
        p_r[k] <= p_r[k-1];
      end
    end
  end

  eaam_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_data[15:0]), .sin_o(sp), .cos_o(cp)
  );
  eaam_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_data[31:16]), .sin_o(sy), .cos_o(cy)
  );
  eaam_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_data[47:32]), .sin_o(sr), .cos_o(cr)
  );

  assign push_data = {p_r[N-1], cr, sr, cy, sy, cp, sp};

endmodule

[hw/rtl/eaam_fifo.sv]
module eaam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = eaam_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/eaam_back.sv]
module eaam_back #(
  parameter int TRIG_FRACTION_BITS = eaam_pkg::TRIG_FRACTION_BITS_DEF,
  parameter int DW                 = 6 * (TRIG_FRACTION_BITS + 2) + 97
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  logic [DW-1:0] pop_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [135:0]  out_data,
  output logic          out_last
);

  localparam int TF = TRIG_FRACTION_BITS;
  localparam int T  = TF + 2;
  localparam int PW = 2 * T;
  localparam int SH_R = (TF >= 16) ? TF - 16 : 0;
  localparam int SH_L = (TF < 16) ? 16 - TF : 0;

  localparam logic signed [PW-1:0] RND  = PW'(64'd1 << (TF - 1));
  localparam logic signed [63:0]   RQ   = (SH_R > 0) ? (64'sd1 <<< (SH_R - 1)) : 64'sd0;
  localparam logic signed [63:0]   MAXV = 64'sd2147483647;
  localparam logic signed [63:0]   MINV = -64'sd2147483648;

  function automatic logic signed [T-1:0] mulf(input logic signed [T-1:0] a,
                                               input logic signed [T-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b + RND;
    return T'(p >>> TF);
  endfunction

  function automatic logic [31:0] toq(input logic signed [T:0] v);
    logic signed [63:0] r;
    r = ((64'(v) + RQ) >>> SH_R) <<< SH_L;
    if (r > MAXV) begin
      r = MAXV;
    end else if (r < MINV) begin
      r = MINV;
    end
    return r[31:0];
  endfunction

  logic signed [T-1:0] sp, cp, sy, cy, sr, cr;
  assign sp = pop_data[T-1:0];
  assign cp = pop_data[2*T-1:T];
  assign sy = pop_data[3*T-1:2*T];
  assign cy = pop_data[4*T-1:3*T];
  assign sr = pop_data[5*T-1:4*T];
  assign cr = pop_data[6*T-1:5*T];

  logic vb_r, vc_r, vm_r;
  logic [1:0] row_r;
  logic free_b, free_c, free_m, load_m;

  // First products.
  logic signed [T-1:0] b_srsp_r, b_crsp_r, b_cpcy_r, b_crsy_r, b_srsy_r;
  logic signed [T-1:0] b_cpsy_r, b_crcy_r, b_srcy_r, b_srcp_r, b_crcp_r;
  logic signed [T-1:0] b_sp_r, b_sy_r, b_cy_r;
  logic [96:0]         b_p_r;
  // Second products.
  logic signed [T-1:0] c_a_r, c_b_r, c_c_r, c_d_r;
  logic signed [T-1:0] c_cpcy_r, c_crsy_r, c_srsy_r, c_cpsy_r, c_crcy_r;
  logic signed [T-1:0] c_srcy_r, c_srcp_r, c_crcp_r, c_sp_r;
  logic [96:0]         c_p_r;
  // Finished rows.
  logic [95:0] row0_r, row1_r, row2_r;
  logic [95:0] org_r;

  assign free_m = !vm_r || (out_ready && row_r == eaam_pkg::LAST_ROW);
  assign free_c = !vc_r || free_m;
  assign free_b = !vb_r || free_c;
  assign pop    = !empty && free_b;
  assign load_m = vc_r && free_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      vm_r  <= 1'b0;
      row_r <= '0;
    end else begin
      if (free_b) begin
        vb_r <= pop;
      end
      if (free_c) begin
        vc_r <= vb_r;
      end
      if (free_m) begin
        vm_r <= vc_r;
      end
      if (vm_r && out_ready) begin
        row_r <= (row_r == eaam_pkg::LAST_ROW) ? 2'd0 : row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_srsp_r <= mulf(sr, sp);
      b_crsp_r <= mulf(cr, sp);
      b_cpcy_r <= mulf(cp, cy);
      b_crsy_r <= mulf(cr, sy);
      b_srsy_r <= mulf(sr, sy);
      b_cpsy_r <= mulf(cp, sy);
      b_crcy_r <= mulf(cr, cy);
      b_srcy_r <= mulf(sr, cy);
      b_srcp_r <= mulf(sr, cp);
      b_crcp_r <= mulf(cr, cp);
      b_sp_r   <= sp;
      b_sy_r   <= sy;
      b_cy_r   <= cy;
      b_p_r    <= pop_data[DW-1:6*T];
    end
  end

  always_ff @(posedge clk) begin
    if (vb_r && free_c) begin
      c_a_r    <= mulf(b_srsp_r, b_cy_r);
      c_b_r    <= mulf(b_crsp_r, b_cy_r);
      c_c_r    <= mulf(b_srsp_r, b_sy_r);
      c_d_r    <= mulf(b_crsp_r, b_sy_r);
      c_cpcy_r <= b_cpcy_r;
      c_crsy_r <= b_crsy_r;
      c_srsy_r <= b_srsy_r;
      c_cpsy_r <= b_cpsy_r;
      c_crcy_r <= b_crcy_r;
      c_srcy_r <= b_srcy_r;
      c_srcp_r <= b_srcp_r;
      c_crcp_r <= b_crcp_r;
      c_sp_r   <= b_sp_r;
      c_p_r    <= b_p_r;
    end
  end

  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  assign m00 = toq((T+1)'(c_cpcy_r));
  assign m01 = toq((T+1)'(c_a_r) - (T+1)'(c_crsy_r));
  assign m02 = toq((T+1)'(c_b_r) + (T+1)'(c_srsy_r));
  assign m10 = toq((T+1)'(c_cpsy_r));
  assign m11 = toq((T+1)'(c_c_r) + (T+1)'(c_crcy_r));
  assign m12 = toq((T+1)'(c_d_r) - (T+1)'(c_srcy_r));
  assign m20 = toq(-(T+1)'(c_sp_r));
  assign m21 = toq((T+1)'(c_srcp_r));
  assign m22 = toq((T+1)'(c_crcp_r));

  always_ff @(posedge clk) begin
    if (load_m) begin
      org_r <= c_p_r[96:1];
      if (c_p_r[0]) begin
        row0_r <= {m20, m10, m00};
        row1_r <= {m21, m11, m01};
        row2_r <= {m22, m12, m02};
      end else begin
        row0_r <= {m02, m01, m00};
        row1_r <= {m12, m11, m10};
        row2_r <= {m22, m21, m20};
      end
    end
  end

  logic [95:0] row_sel;
  logic [31:0] org_sel;

  always_comb begin
    case (row_r)
      2'd0: begin
        row_sel = row0_r;
        org_sel = org_r[31:0];
      end
      2'd1: begin
        row_sel = row1_r;
        org_sel = org_r[63:32];
      end
      default: begin
        row_sel = row2_r;
        org_sel = org_r[95:64];
      end
    endcase
  end

  assign out_valid = vm_r;
  assign out_last  = (row_r == eaam_pkg::LAST_ROW);
  assign out_data  = {6'b0, org_sel, row_sel, row_r};

endmodule

[hw/rtl/euler_angles_to_affine_matrix.sv]
// An accepted transaction passes the CORDIC stages, the queue, the first- and
// second-product registers and the row registers; its three rows then leave in turn
// while out_tready stays high; the single result channel bounds the transform rate.
// The 32-stage CORDIC accepts one angle set a cycle unless stalled by a full queue.
// Reset (synchronous, active low) clears the valid bits, the row counter and the
// queue pointers and count; data registers keep their contents.
module euler_angles_to_affine_matrix #(
  parameter int ANGLE_BITS         = eaam_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRACTION_BITS = eaam_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pitch_angle, yaw_angle, roll_angle, origin_x, origin_y, origin_z
  input  logic [143:0] in_tdata,
  // op
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index, col_zero, col_one, col_two, col_three, zero fill
  output logic [135:0] out_tdata,
  output logic         out_tlast
);

  localparam int DW = 6 * (TRIG_FRACTION_BITS + 2) + 97;

  logic          push, full, pop, empty;
  logic [DW-1:0] push_data, pop_data;

  eaam_front #(
    .ANGLE_BITS(ANGLE_BITS),
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
    .DW(DW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_data(in_tdata), .in_op(in_tuser),
    .push(push), .push_data(push_data), .full(full)
  );

  eaam_fifo #(.WIDTH(DW), .DEPTH(eaam_pkg::FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .empty(empty)
  );

  eaam_back #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS), .DW(DW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .empty(empty), .pop_data(pop_data), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata), .out_last(out_tlast)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic        op;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
  } pose_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic        last;
  } row_t;

  localparam int FRAC  = eaam_pkg::TRIG_FRACTION_BITS_DEF;
  localparam int WORK  = FRAC + eaam_pkg::GUARD_BITS;
  localparam int LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tlast;
  logic         in_tready_seen = 1'b0;

  pose_t pending_poses[$];
  row_t  expected_rows[$];
  int    mismatches = 0;
  int    cycle_count = 0;
  int    hold_off = 0;
  bit    stimulus_done = 1'b0;
  int    send_gap = 0;
  int    recv_gap = 0;

  euler_angles_to_affine_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Rotates within one quadrant, then maps the result by the top phase bits.
  function automatic void sine_cosine(input logic [15:0] ang, output longint sn,
                                      output longint cs);
    longint one, x, y, z, dx, dy, c, s, t;
    logic [31:0] phase;
    logic [1:0] quad;
    one = longint'(1) << FRAC;
    phase = {ang & eaam_pkg::angle_mask(eaam_pkg::ANGLE_BITS_DEF), 16'h0};
    quad = phase[31:30];
    z = longint'(phase[29:0]);
    x = longint'(eaam_pkg::cordic_gain(WORK));
    y = 0;
    for (int i = 0; i < eaam_pkg::CORDIC_STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(eaam_pkg::atan_entry(i));
      end else begin
        x += dx; y -= dy; z += longint'(eaam_pkg::atan_entry(i));
      end
    end
    c = rnd_shift(x, eaam_pkg::GUARD_BITS);
    s = rnd_shift(y, eaam_pkg::GUARD_BITS);
    if (c > one) c = one;
    if (c < -one) c = -one;
    if (s > one) s = one;
    if (s < -one) s = -one;
    case (quad)
      2'd1: begin t = c; c = -s; s = t; end
      2'd2: begin c = -c; s = -s; end
      2'd3: begin t = c; c = s; s = -t; end
      default: ;
    endcase
    sn = s;
    cs = c;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return rnd_shift(a * b, FRAC);
  endfunction

  function automatic logic [31:0] sat_q16(longint v);
    longint r;
    r = (FRAC >= 16) ? rnd_shift(v, FRAC - 16) : v * (longint'(1) << (16 - FRAC));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_matrix(input pose_t p);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    longint m[3][3];
    logic [31:0] org[3];
    row_t r;
    sine_cosine(p.pitch, sp, cp);
    sine_cosine(p.yaw, sy, cy);
    sine_cosine(p.roll, sr, cr);
    srsp = fmul(sr, sp);
    crsp = fmul(cr, sp);
    m[0][0] = fmul(cp, cy);
    m[0][1] = fmul(srsp, cy) - fmul(cr, sy);
    m[0][2] = fmul(crsp, cy) + fmul(sr, sy);
    m[1][0] = fmul(cp, sy);
    m[1][1] = fmul(srsp, sy) + fmul(cr, cy);
    m[1][2] = fmul(crsp, sy) - fmul(sr, cy);
    m[2][0] = -sp;
    m[2][1] = fmul(sr, cp);
    m[2][2] = fmul(cr, cp);
    org = '{p.ox, p.oy, p.oz};
    for (int i = 0; i < 3; i++) begin
      r.row  = 2'(i);
      r.c0   = sat_q16(p.op ? m[0][i] : m[i][0]);
      r.c1   = sat_q16(p.op ? m[1][i] : m[i][1]);
      r.c2   = sat_q16(p.op ? m[2][i] : m[i][2]);
      r.c3   = org[i];
      r.last = (2'(i) == eaam_pkg::LAST_ROW);
      expected_rows.push_back(r);
    end
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  initial begin
    pose_t p;
    logic [15:0] dir[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                            16'hFFFF, 16'h2000, 16'h0001, 16'h7FFF};
    for (int i = 0; i < 8; i++) begin
      p.op = i[0];
      p.pitch = dir[i];
      p.yaw = dir[(i + 3) % 8];
      p.roll = dir[(i + 5) % 8];
      p.ox = (i < 4) ? 32'h7FFF_FFFF : 32'h8000_0000;
      p.oy = (i < 4) ? 32'h8000_0000 : 32'h0000_0000;
      p.oz = (i < 4) ? 32'hFFFF_FFFF : 32'h0001_0000;
      pending_poses.push_back(p);
    end
    for (int i = 0; i < 4; i++) begin
      p = '{op: i[0], pitch: 16'hFFFF * i[1], yaw: 16'hFFFF * i[0],
            roll: 16'hFFFF * (i[0] ^ i[1]), ox: 32'hFFFF_FFFF, oy: 32'h7FFF_FFFF,
            oz: 32'h8000_0000};
      pending_poses.push_back(p);
    end
    for (int i = 0; i < 200; i++) begin
      p.op = 1'($urandom);
      p.pitch = rand_angle();
      p.yaw = rand_angle();
      p.roll = rand_angle();
      p.ox = rand_origin();
      p.oy = rand_origin();
      p.oz = rand_origin();
      pending_poses.push_back(p);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) in_tready_seen <= in_tready;

  // Driver. The transaction is taken on the rising edge; the next is set up on the falling one.
  always @(negedge clk) begin
    pose_t p;
    if (rst_n) begin
      if (in_tvalid && in_tready_seen) send_gap = rand_gap();
      if (!in_tvalid || in_tready_seen) begin
        if (send_gap > 0 || pending_poses.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_tvalid <= 1'b0;
        end else begin
          p = pending_poses.pop_front();
          predict_matrix(p);
          in_tdata <= {p.oz, p.oy, p.ox, p.roll, p.yaw, p.pitch};
          in_tuser <= p.op;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // One long hold-off early on so the pipeline backs up into in_tready.
  always @(posedge clk) begin
    if (cycle_count == 200) begin
      hold_off <= 300;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    row_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.row  = out_tdata[1:0];
      got.c0   = out_tdata[33:2];
      got.c1   = out_tdata[65:34];
      got.c2   = out_tdata[97:66];
      got.c3   = out_tdata[129:98];
      got.last = out_tlast;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row transaction %h", got);
      end else begin
        want = expected_rows.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("row mismatch: expected row %0d %h %h %h %h last %b",
                     want.row, want.c0, want.c1, want.c2, want.c3, want.last);
            $display("              got row %0d %h %h %h %h last %b",
                     got.row, got.c0, got.c1, got.c2, got.c3, got.last);
          end
        end
      end
    end
  end

  initial begin
    wait (stimulus_done);
    while ((pending_poses.size() > 0 || in_tvalid || expected_rows.size() > 0) &&
           cycle_count < LIMIT)
      @(posedge clk);
    if (cycle_count >= LIMIT) begin
      $display("testbench NOT OK");
    end else begin
      repeat (60) @(posedge clk);
      if (mismatches == 0) begin
        $display("testbench OK");
      end else begin
        $display("testbench NOT OK");
      end
    end
    $finish;
  end

endmodule
